// ===== hw/rtl/vwp_pkg.sv =====
// ----------------------------------------------------------------------------
// vwp_pkg: shared types and constants for the vertex window projection
// Field widths, queue item layout, command codes and saturation helper.
// ----------------------------------------------------------------------------
package vwp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_W           = 32;   // coordinate / coefficient width
  localparam int P_W           = 2 * Q_W;
  localparam int W_W           = Q_W + 1;  // eye w after negation
  localparam int SAT_W         = 72;   // wide accumulator width
  localparam int VP_W          = 14;
  localparam int IDX_W         = 5;
  localparam int COEF_N        = 16;
  localparam int FIFO_DEPTH    = 8;
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_VP_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VP_W = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VP_H = 4'd3;

  typedef struct packed {
    logic [VP_W-1:0] x;
    logic [VP_W-1:0] y;
    logic [VP_W-1:0] w;
    logic [VP_W-1:0] h;
  } vp_t;

  // one queue entry: a load beat or an eye-space point
  typedef struct packed {
    logic                  load;
    logic [IDX_W-1:0]      idx;
    logic [Q_W-1:0]        value;
    logic [3:0][Q_W-1:0]   eye;
  } q_item_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[Q_W-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[Q_W-1:0];
    else r = v[Q_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/vwp_ifs.sv =====
// ----------------------------------------------------------------------------
// vwp_ifs: channel interfaces
// Input, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vwp_in_if;
  import vwp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [IDX_W-1:0]      coef_index;
  logic signed [Q_W-1:0] coef_value;
  logic signed [Q_W-1:0] obj_x;
  logic signed [Q_W-1:0] obj_y;
  logic signed [Q_W-1:0] obj_z;
  modport source (output valid, cmd, coef_index, coef_value, obj_x, obj_y, obj_z,
                  input ready);
  modport sink   (input valid, cmd, coef_index, coef_value, obj_x, obj_y, obj_z,
                  output ready);
endinterface

interface vwp_out_if;
  import vwp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  point_valid;
  logic signed [Q_W-1:0] win_x;
  logic signed [Q_W-1:0] win_y;
  logic signed [Q_W-1:0] win_z;
  modport source (output valid, point_valid, win_x, win_y, win_z, input ready);
  modport sink   (input valid, point_valid, win_x, win_y, win_z, output ready);
endinterface

interface vwp_cfg_if;
  import vwp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/vertex_window_projection.sv =====
// ----------------------------------------------------------------------------
// vertex_window_projection: object space to window coordinates
// Modelview and projection transform, perspective divide, viewport map.
// ----------------------------------------------------------------------------
// Channels: in_ch carries load beats (cmd 0, one coefficient, no result) and
// project beats (cmd 1, one point, one result). out_ch carries one result per
// project beat, in order. cfg_ch writes the viewport registers; it is always
// ready. It must be written only while the block is idle; the block does not enforce this.
// Throughput: one beat per cycle on in_ch and one result per cycle on out_ch,
// while out_ch is not stalled and the queue has room.
// Path from an accepted project beat to its result: two modelview stages, the
// queue, two projection stages, a 33-stage divider (an overflow check, then
// one quotient bit per stage), its saturation register and two viewport stages.
// Reset clears all coefficients, the viewport registers and every pipeline valid bit.
// When out_ch stalls, the back pipeline holds; the front keeps taking beats
// until the queue and its two stages together hold eight beats.
module vertex_window_projection #(
  parameter int FRAC_BITS = vwp_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  vwp_in_if.sink     in_ch,
  vwp_out_if.source  out_ch,
  vwp_cfg_if.sink    cfg_ch
);
  import vwp_pkg::*;

  vp_t             vp_r;
  logic            push, pop, q_empty;
  q_item_t         push_item, q_item;
  logic [CNT_W-1:0] q_count;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_VP_X: vp_r.x <= cfg_ch.data[VP_W-1:0];
        REG_VP_Y: vp_r.y <= cfg_ch.data[VP_W-1:0];
        REG_VP_W: vp_r.w <= cfg_ch.data[VP_W-1:0];
        REG_VP_H: vp_r.h <= cfg_ch.data[VP_W-1:0];
        default:  ;
      endcase
    end
  end

  vwp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  vwp_fifo #(.DEPTH(FIFO_DEPTH), .W($bits(q_item_t))) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_item),
    .pop   (pop),
    .rdata (q_item),
    .empty (q_empty),
    .count (q_count)
  );

  vwp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vp      (vp_r),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );
endmodule

// ===== hw/rtl/vwp_fifo.sv =====
// ----------------------------------------------------------------------------
// vwp_fifo: small register queue
// Decouples the front (modelview) side from the back (projection) side.
// ----------------------------------------------------------------------------
module vwp_fifo #(
  parameter int DEPTH = vwp_pkg::FIFO_DEPTH,
  parameter int W     = $bits(vwp_pkg::q_item_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int C_W   = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [C_W-1:0]   count_r;

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end
endmodule

// ===== hw/rtl/vwp_front.sv =====
// ----------------------------------------------------------------------------
// vwp_front: input side
// Takes beats, writes modelview coefficients, transforms points to eye space.
// ----------------------------------------------------------------------------
module vwp_front #(
  parameter int FRAC_BITS = vwp_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  vwp_in_if.sink                     in_ch,
  input  logic [vwp_pkg::CNT_W-1:0]  q_count,
  output logic                       push,
  output vwp_pkg::q_item_t           push_item
);
  import vwp_pkg::*;

  localparam logic signed [SAT_W-1:0] HALF = SAT_W'(1) << (FRAC_BITS - 1);

  logic signed [Q_W-1:0] mv_r [COEF_N];
  logic                  v1_r, v2_r;
  logic                  ld1_r;
  logic [IDX_W-1:0]      idx1_r;
  logic [Q_W-1:0]        val1_r;
  logic signed [P_W-1:0] p1_r [4][3];
  logic signed [Q_W-1:0] t1_r [4];
  logic signed [Q_W-1:0] eye_nxt [4];
  logic signed [Q_W-1:0] obj [3];
  q_item_t               item2_r;
  logic [CNT_W:0]        used;
  logic                  accept;
  logic                  is_load;

  assign obj[0] = in_ch.obj_x;
  assign obj[1] = in_ch.obj_y;
  assign obj[2] = in_ch.obj_z;

  // credit: queue entries plus beats still in the two front stages
  assign used        = {1'b0, q_count} + (CNT_W+1)'(v1_r) + (CNT_W+1)'(v2_r);
  assign in_ch.ready = (used < (CNT_W+1)'(FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_load     = (cmd_t'(in_ch.cmd) == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int i = 0; i < COEF_N; i++) mv_r[i] <= '0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      if (accept && is_load && !in_ch.coef_index[IDX_W-1])
        mv_r[in_ch.coef_index[IDX_W-2:0]] <= in_ch.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    ld1_r  <= is_load;
    idx1_r <= in_ch.coef_index;
    val1_r <= in_ch.coef_value;
    for (int r = 0; r < 4; r++) begin
      t1_r[r] <= mv_r[12 + r];
      for (int c = 0; c < 3; c++) p1_r[r][c] <= mv_r[4*c + r] * obj[c];
    end
  end

  always_comb begin
    logic signed [SAT_W-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = SAT_W'(t1_r[r]);
      for (int c = 0; c < 3; c++) acc = acc + ((SAT_W'(p1_r[r][c]) + HALF) >>> FRAC_BITS);
      eye_nxt[r] = sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    item2_r.load  <= ld1_r;
    item2_r.idx   <= idx1_r;
    item2_r.value <= val1_r;
    for (int r = 0; r < 4; r++) item2_r.eye[r] <= eye_nxt[r];
  end

  assign push      = v2_r;
  assign push_item = item2_r;
endmodule

// ===== hw/rtl/vwp_div.sv =====
// ----------------------------------------------------------------------------
// vwp_div: pipelined restoring divider
// One quotient bit per step stage; flags quotients that do not fit in Q_W bits.
// ----------------------------------------------------------------------------
module vwp_div #(
  parameter int FRAC_BITS = vwp_pkg::FRAC_BITS_DEF,
  parameter int NW        = vwp_pkg::Q_W + FRAC_BITS + 2
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NW-1:0]          n,
  input  logic [vwp_pkg::Q_W:0]  d,
  input  logic                   neg,
  output logic [vwp_pkg::Q_W-1:0] q,
  output logic                   ovf,
  output logic                   neg_o
);
  import vwp_pkg::*;

  localparam int DW = Q_W + 1;
  localparam int HW = NW - Q_W;

  logic [DW-1:0]  rem_r  [Q_W+1];
  logic [Q_W-1:0] low_r  [Q_W+1];
  logic [Q_W-1:0] quo_r  [Q_W+1];
  logic [DW-1:0]  d_r    [Q_W+1];
  logic           ovf_r  [Q_W+1];
  logic           neg_r  [Q_W+1];
  logic [HW-1:0]  hi;
  logic           ovf_in;

  assign hi     = n[NW-1:Q_W];
  assign ovf_in = ({(DW+1)'(hi)} >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf_in ? '0 : DW'(hi);
      low_r[0] <= n[Q_W-1:0];
      quo_r[0] <= '0;
      d_r[0]   <= d;
      ovf_r[0] <= ovf_in;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem_r[k-1], low_r[k-1][Q_W-1]};
    assign ge = (t >= {1'b0, d_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(t - {1'b0, d_r[k-1]}) : t[DW-1:0];
        low_r[k] <= {low_r[k-1][Q_W-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][Q_W-2:0], ge};
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign q     = quo_r[Q_W];
  assign ovf   = ovf_r[Q_W];
  assign neg_o = neg_r[Q_W];
endmodule

// ===== hw/rtl/vwp_back.sv =====
// ----------------------------------------------------------------------------
// vwp_back: output side
// Projection matrix, perspective divide, viewport map, result register.
// ----------------------------------------------------------------------------
module vwp_back #(
  parameter int FRAC_BITS = vwp_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vwp_pkg::vp_t     vp,
  input  vwp_pkg::q_item_t q_item,
  input  logic             q_empty,
  output logic             q_pop,
  vwp_out_if.source        out_ch
);
  import vwp_pkg::*;

  localparam int NW      = Q_W + FRAC_BITS + 2;
  localparam int DIV_LAT = Q_W + 1;
  localparam int MV_W    = Q_W + 1 + VP_W + 1;
  localparam logic signed [SAT_W-1:0] HALF  = SAT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [Q_W:0]     ONE_X = (Q_W+1)'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0]          POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0]          NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

  logic                  be;
  logic signed [Q_W-1:0] pr_r [COEF_N];
  logic signed [Q_W-1:0] eye_in [4];

  logic                  b1_v_r;
  logic signed [P_W-1:0] b1_p_r [3][4];
  logic signed [W_W-1:0] b1_w_r;

  logic                  b2_v_r;
  logic signed [Q_W-1:0] b2_clip_r [3];
  logic signed [W_W-1:0] b2_w_r;
  logic signed [Q_W-1:0] clip_nxt [3];

  logic [NW-1:0]         dv_n [3];
  logic [Q_W:0]          dv_d;
  logic                  dv_neg [3];
  logic [Q_W-1:0]        dq [3];
  logic                  dovf [3];
  logic                  dneg [3];
  logic                  wzero;
  logic                  ctl_v_r [DIV_LAT];
  logic                  ctl_z_r [DIV_LAT];

  logic signed [Q_W-1:0] ndc_nxt [3];
  logic signed [Q_W-1:0] ndc_r [3];
  logic                  b3_v_r, b3_z_r;

  logic signed [MV_W-1:0] v1_px_r, v1_py_r;
  logic signed [Q_W:0]    v1_z_r;
  logic                   v1_v_r, v1_wz_r;

  logic signed [Q_W-1:0] wx_nxt, wy_nxt, wz_nxt;
  logic                  out_valid_r;
  logic                  out_pv_r;
  logic signed [Q_W-1:0] out_x_r, out_y_r, out_z_r;

  assign be    = !out_valid_r || out_ch.ready;
  assign q_pop = be && !q_empty;

  for (genvar c = 0; c < 4; c++) begin : g_eye
    assign eye_in[c] = q_item.eye[c];
  end

  // projection coefficients: loads take effect in queue order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEF_N; i++) pr_r[i] <= '0;
    end else if (q_pop && q_item.load && q_item.idx[IDX_W-1]) begin
      pr_r[q_item.idx[IDX_W-2:0]] <= q_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      v1_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) ctl_v_r[k] <= 1'b0;
    end else if (be) begin
      b1_v_r <= q_pop && !q_item.load;
      b2_v_r <= b1_v_r;
      ctl_v_r[0] <= b2_v_r;
      for (int k = 1; k < DIV_LAT; k++) ctl_v_r[k] <= ctl_v_r[k-1];
      b3_v_r <= ctl_v_r[DIV_LAT-1];
      v1_v_r <= b3_v_r;
      out_valid_r <= v1_v_r;
    end
  end

  always_comb begin
    logic signed [SAT_W-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) acc = acc + ((SAT_W'(b1_p_r[r][c]) + HALF) >>> FRAC_BITS);
      clip_nxt[r] = sat32(acc);
    end
  end

  // divide setup: |clip| * 2^F * 2 + |w| over 2|w| rounds half away from zero
  always_comb begin
    logic signed [W_W-1:0] wa;
    logic signed [Q_W:0]   ca;
    logic [Q_W-1:0]        ud;
    wa    = b2_w_r[W_W-1] ? -b2_w_r : b2_w_r;
    ud    = wa[Q_W-1:0];
    dv_d  = {ud, 1'b0};
    wzero = (b2_w_r == '0);
    for (int r = 0; r < 3; r++) begin
      ca = (Q_W+1)'(b2_clip_r[r]);
      ca = ca[Q_W] ? -ca : ca;
      dv_n[r]   = {1'b0, ca[Q_W-1:0], {FRAC_BITS{1'b0}}, 1'b0} + NW'(ud);
      dv_neg[r] = b2_clip_r[r][Q_W-1] ^ b2_w_r[W_W-1];
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_div
    vwp_div #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_div (
      .clk   (clk),
      .en    (be),
      .n     (dv_n[r]),
      .d     (dv_d),
      .neg   (dv_neg[r]),
      .q     (dq[r]),
      .ovf   (dovf[r]),
      .neg_o (dneg[r])
    );
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (dneg[r]) begin
        if (dovf[r] || (dq[r] > NEG_MAX)) ndc_nxt[r] = NEG_MAX;
        else ndc_nxt[r] = -dq[r];
      end else begin
        if (dovf[r] || (dq[r] > POS_MAX)) ndc_nxt[r] = POS_MAX;
        else ndc_nxt[r] = dq[r];
      end
    end
  end

  always_comb begin
    logic signed [SAT_W-1:0] sx, sy, sz;
    sx = SAT_W'(v1_px_r) + $signed(SAT_W'(vp.x) << (FRAC_BITS + 1)) + SAT_W'(1);
    sy = SAT_W'(v1_py_r) + $signed(SAT_W'(vp.y) << (FRAC_BITS + 1)) + SAT_W'(1);
    sz = SAT_W'(v1_z_r) + SAT_W'(1);
    wx_nxt = sat32(sx >>> 1);
    wy_nxt = sat32(sy >>> 1);
    wz_nxt = sat32(sz >>> 1);
  end

  always_ff @(posedge clk) begin
    if (be) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++) b1_p_r[r][c] <= pr_r[4*c + r] * eye_in[c];
      b1_w_r <= -W_W'(eye_in[2]);

      for (int r = 0; r < 3; r++) b2_clip_r[r] <= clip_nxt[r];
      b2_w_r <= b1_w_r;

      ctl_z_r[0] <= wzero;
      for (int k = 1; k < DIV_LAT; k++) ctl_z_r[k] <= ctl_z_r[k-1];

      for (int r = 0; r < 3; r++) ndc_r[r] <= ndc_nxt[r];
      b3_z_r <= ctl_z_r[DIV_LAT-1];

      v1_px_r <= ((Q_W+1)'(ndc_r[0]) + ONE_X) * $signed({1'b0, vp.w});
      v1_py_r <= ((Q_W+1)'(ndc_r[1]) + ONE_X) * $signed({1'b0, vp.h});
      v1_z_r  <= (Q_W+1)'(ndc_r[2]) + ONE_X;
      v1_wz_r <= b3_z_r;

      out_pv_r <= !v1_wz_r;
      out_x_r  <= v1_wz_r ? '0 : wx_nxt;
      out_y_r  <= v1_wz_r ? '0 : wy_nxt;
      out_z_r  <= v1_wz_r ? '0 : wz_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_valid = out_pv_r;
  assign out_ch.win_x       = out_x_r;
  assign out_ch.win_y       = out_y_r;
  assign out_ch.win_z       = out_z_r;
endmodule

// ===== hw/rtl/vwp_checker.sv =====
// ----------------------------------------------------------------------------
// vwp_checker: port-level checks
// Result channel behavior seen at the top level's ports.
// ----------------------------------------------------------------------------
module vwp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_point_valid,
  input logic [31:0] out_win_x,
  input logic [31:0] out_win_y,
  input logic [31:0] out_win_z,
  input logic        cfg_ready
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_win_x) && $stable(out_win_y)
      && $stable(out_win_z) && $stable(out_point_valid))
    else $error("result beat changed while stalled");

  // failed projection reports zero coordinates
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_win_x == 32'd0 && out_win_y == 32'd0
      && out_win_z == 32'd0)
    else $error("failed projection with nonzero coordinates");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");
endmodule

bind vertex_window_projection vwp_checker u_vwp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_point_valid (out_ch.point_valid),
  .out_win_x       (out_ch.win_x),
  .out_win_y       (out_ch.win_y),
  .out_win_z       (out_ch.win_z),
  .cfg_ready       (cfg_ch.ready)
);

// ===== test/tb_vertex_window_projection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_window_projection: self-checking bench for the projection block
// Loads matrices, projects points through several viewports and compares
// every result beat against a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_vertex_window_projection;
  import vwp_pkg::*;

  localparam int LATENCY   = 41;
  localparam int WDOG_MAX  = 20000;
  localparam int FB        = FRAC_BITS_DEF;

  typedef struct {
    logic            cmd;
    logic [4:0]      idx;
    logic [31:0]     cval;
    logic [31:0]     x;
    logic [31:0]     y;
    logic [31:0]     z;
  } beat_t;

  typedef struct {
    logic        pv;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
  } win_t;

  logic clk;
  logic rst_n;

  vwp_in_if  in_ch ();
  vwp_out_if out_ch ();
  vwp_cfg_if cfg_ch ();

  vertex_window_projection i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  beat_t pending_beats[$];
  win_t  expected_points[$];

  longint mv[16];
  longint pj[16];
  longint vp_x, vp_y, vp_w, vp_h;

  int  mismatches;
  int  results_seen;
  int  beats_sent;
  int  idle_cycles;
  bit  quiet_mode;      // no idling in the final stretch
  bit  hold_off;
  int  hold_cnt;
  int  src_gap;
  int  snk_gap;
  bit  timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_beat(beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint v, int s);
    longint u;
    u = v + (longint'(1) << (s - 1));
    return u >>> s;
  endfunction

  function automatic longint div_near(longint n, longint d);
    bit neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    return neg ? -q : q;
  endfunction

  // applies a beat to the predictor's matrices; returns 1 if a result follows
  function automatic bit project_beat(beat_t b, output win_t r);
    longint one, s, w, wx, wy, wz;
    longint obj[3], eye[4], clip[3], ndc[3];
    one = longint'(1) << FB;
    r = '{1'b0, '0, '0, '0};
    if (b.cmd == CMD_LOAD) begin
      if (b.idx < 16) mv[b.idx] = longint'(signed'(b.cval));
      else pj[b.idx - 16] = longint'(signed'(b.cval));
      return 1'b0;
    end
    obj[0] = longint'(signed'(b.x));
    obj[1] = longint'(signed'(b.y));
    obj[2] = longint'(signed'(b.z));
    for (int i = 0; i < 4; i++) begin
      s = mv[12 + i];
      for (int c = 0; c < 3; c++) s += rnd_shift(mv[4 * c + i] * obj[c], FB);
      eye[i] = sat_q(s);
    end
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int c = 0; c < 4; c++) s += rnd_shift(pj[4 * c + i] * eye[c], FB);
      clip[i] = sat_q(s);
    end
    w = -eye[2];
    if (w == 0) return 1'b1;
    for (int i = 0; i < 3; i++) ndc[i] = sat_q(div_near(clip[i] * one, w));
    wx = (ndc[0] + one) * vp_w + 2 * vp_x * one;
    wy = (ndc[1] + one) * vp_h + 2 * vp_y * one;
    wz = one + ndc[2];
    r.pv = 1'b1;
    r.wx = 32'(sat_q(rnd_shift(wx, 1)));
    r.wy = 32'(sat_q(rnd_shift(wy, 1)));
    r.wz = 32'(sat_q(rnd_shift(wz, 1)));
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
    endcase
  endfunction

  function automatic beat_t load_beat(int idx, logic [31:0] v);
    beat_t b;
    b.cmd = CMD_LOAD; b.idx = 5'(idx); b.cval = v;
    b.x = $urandom; b.y = $urandom; b.z = $urandom;
    return b;
  endfunction

  function automatic beat_t point_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    beat_t b;
    b.cmd = CMD_PROJECT; b.idx = 5'($urandom); b.cval = $urandom;
    b.x = x; b.y = y; b.z = z;
    return b;
  endfunction

  // typical camera: identity modelview shifted back, perspective projection
  task automatic queue_camera();
    for (int i = 0; i < 32; i++) begin
      logic [31:0] v;
      v = 0;
      if (i < 16 && (i % 5) == 0) v = 1 << FB;
      if (i == 14) v = -(5 << FB);
      if (i == 16) v = 32'($urandom_range(1 << (FB - 2), 3 << FB));
      if (i == 21) v = 32'($urandom_range(1 << (FB - 2), 3 << FB));
      if (i == 26) v = -(32'd1 << FB) - 32'($urandom_range(0, 1 << FB));
      if (i == 30) v = -(32'd2 << FB) - 32'($urandom_range(0, 1 << FB));
      if (i == 27) v = -(32'd1 << FB);
      if ($urandom_range(0, 9) == 0) v = v + 32'($urandom_range(0, 1 << (FB - 3)));
      add_beat(load_beat(i, v));
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_ch.valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // leaves valid high so that writes follow back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_VP_X: vp_x = data[13:0];
      REG_VP_Y: vp_y = data[13:0];
      REG_VP_W: vp_w = data[13:0];
      REG_VP_H: vp_h = data[13:0];
      default: ;
    endcase
  endtask

  task automatic set_viewport(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [31:0] h);
    write_reg(REG_VP_X, x);
    write_reg(REG_VP_Y, y);
    write_reg(REG_VP_W, w);
    write_reg(REG_VP_H, h);
    cfg_ch.valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      beat_t b;
      win_t  r;
      bit    fire, load_next;
      fire = in_ch.valid && in_ch.ready;
      if (fire) beats_sent <= beats_sent + 1;
      load_next = !in_ch.valid || fire;
      if (load_next) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          b = pending_beats.pop_front();
          if (project_beat(b, r)) expected_points.insert(expected_points.size(), r);
          in_ch.valid      <= 1'b1;
          in_ch.cmd        <= b.cmd;
          in_ch.coef_index <= b.idx;
          in_ch.coef_value <= b.cval;
          in_ch.obj_x      <= b.x;
          in_ch.obj_y      <= b.y;
          in_ch.obj_z      <= b.z;
          if (!quiet_mode && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 11);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
      hold_cnt <= 0;
    end else begin
      win_t e;
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_points.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        end else begin
          e = expected_points.pop_front();
          if (out_ch.point_valid !== e.pv || out_ch.win_x !== e.wx ||
              out_ch.win_y !== e.wy || out_ch.win_z !== e.wz) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("ERROR: exp pv=%0d x=%h y=%h z=%h got pv=%0d x=%h y=%h z=%h",
                       e.pv, e.wx, e.wy, e.wz, out_ch.point_valid,
                       out_ch.win_x, out_ch.win_y, out_ch.win_z);
          end
        end
      end
      if (hold_off && hold_cnt < 300) begin
        hold_cnt <= hold_cnt + 1;
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
        snk_gap <= $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      timed_out = 1'b1;
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0; results_seen = 0; beats_sent = 0; idle_cycles = 0;
    quiet_mode = 0; hold_off = 0; timed_out = 0;
    vp_x = 0; vp_y = 0; vp_w = 0; vp_h = 0;
    for (int i = 0; i < 16; i++) begin mv[i] = 0; pj[i] = 0; end
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.cmd = CMD_LOAD; in_ch.coef_index = '0;
    in_ch.coef_value = '0; in_ch.obj_x = '0; in_ch.obj_y = '0; in_ch.obj_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero matrices give zero w, then extremes
    add_beat(point_beat(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF));
    wait_drained();
    set_viewport(0, 0, 640, 480);
    queue_camera();
    add_beat(point_beat(0, 0, 0));
    add_beat(point_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_beat(point_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_beat(point_beat(32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000));
    add_beat(point_beat(32'hFFFF_FFFF, 32'h0000_0001, 32'h0005_0000));
    // eye z of zero despite loaded matrices
    add_beat(point_beat(0, 0, 32'h0005_0000));
    add_beat(load_beat(31, 32'h7FFF_FFFF));
    add_beat(load_beat(0, 32'h8000_0000));
    add_beat(point_beat(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_viewport(32'h3FFF, 32'h3FFF, 32'h3FFF, 32'h3FFF);
        1: set_viewport(0, 0, 0, 0);
        2: set_viewport($urandom, $urandom, $urandom, $urandom);
        3: set_viewport(100, 50, 1920, 1080);
        default: set_viewport(32'hFFFF_C000, 7, 32'hFFFF_FFFF, 1);
      endcase
      if (phase == 4) quiet_mode = 1;
      queue_camera();
      for (int n = 0; n < 190; n++) begin
        case ($urandom_range(0, 19))
          0: add_beat(load_beat($urandom_range(0, 31), rand_q()));
          1: add_beat(point_beat($urandom, $urandom, $urandom));
          2: add_beat(point_beat(0, 0, 32'h0005_0000));
          default: add_beat(point_beat(
              32'($signed($urandom_range(0, 20 << FB)) - (10 << FB)),
              32'($signed($urandom_range(0, 20 << FB)) - (10 << FB)),
              32'($signed($urandom_range(0, 8 << FB)) - (4 << FB))));
        endcase
      end
      if (phase == 1) begin
        hold_cnt = 0;
        hold_off = 1;
      end
      wait_drained();
      hold_off = 0;
    end

    $display("Projected %0d result beats from %0d input beats over six viewport settings,",
             results_seen, beats_sent);
    $display("including zero-w points, saturating extremes and a long output stall.");
    if (mismatches == 0 && !timed_out) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
